>>> rtl/bslu_pkg.sv
// ----------------------------------------------------------------------------
// bslu_pkg
// Shared types and constants of the bitblt shift and logic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bslu_pkg;

    localparam int WORD_W     = 16;
    localparam int CFG_W      = 4;
    localparam int SHIFT_W    = 4;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [WORD_W-1:0]  WORD_ONES = '1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = '1;

    typedef enum logic [1:0] {
        OP_SRC_WRITE = 2'd0,
        OP_DST_WRITE = 2'd1,
        OP_OUT_READ  = 2'd2,
        OP_PIX_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_FUNCTION_SELECT  = 2'd0,
        CFG_BARREL_SHIFT     = 2'd1,
        CFG_LEFT_MASK_SHIFT  = 2'd2,
        CFG_RIGHT_MASK_SHIFT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_op                operation;
        logic [WORD_W-1:0]  bus_word;
        logic               push_fifo;
        logic               shift_direction;
        logic               line_mode;
        logic               pixel_level;
        logic               left_enable;
        logic               right_enable;
        logic               output_select;
        logic [SHIFT_W-1:0] pixel_index;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] read_word;
        logic              fifo_overflow;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0]   function_select;
        logic [SHIFT_W-1:0] barrel_shift;
        logic [SHIFT_W-1:0] left_mask_shift;
        logic [SHIFT_W-1:0] right_mask_shift;
    } t_cfg;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [WORD_W-1:0] wdata;
    } t_fifo_ctl;

    typedef struct packed {
        logic source_we;
        logic logic_we;
        logic popped_we;
    } t_latch_ctl;

endpackage

`default_nettype wire

>>> rtl/bslu_in_if.sv
// ----------------------------------------------------------------------------
// bslu_in_if
// Valid/ready channel carrying one bus access into the unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface bslu_in_if;
    import bslu_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> rtl/bslu_out_if.sv
// ----------------------------------------------------------------------------
// bslu_out_if
// Valid/ready channel carrying one result word out of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface bslu_out_if;
    import bslu_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> rtl/bslu_fifo.sv
// ----------------------------------------------------------------------------
// bslu_fifo
// Ring buffer of source words with free-running pointers; overflow is
// flagged when a push catches up with the read pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module bslu_fifo (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  bslu_pkg::t_fifo_ctl         i_ctl,
    output logic [bslu_pkg::WORD_W-1:0] o_rdata,
    output logic                        o_overflow
);
    import bslu_pkg::*;

    localparam logic [FIFO_AW-1:0] PTR_LAST = FIFO_AW'(FIFO_DEPTH - 1);

    logic [WORD_W-1:0]  r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] n_rd_ptr;
    logic [FIFO_AW-1:0] n_wr_ptr;
    logic [FIFO_AW-1:0] w_rd_inc;
    logic [FIFO_AW-1:0] w_wr_inc;

    always_comb begin
        w_rd_inc = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        w_wr_inc = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = i_ctl.pop  ? w_rd_inc : r_rd_ptr;
        n_wr_ptr = i_ctl.push ? w_wr_inc : r_wr_ptr;
    end

    // the pop of the same access is taken into account before the compare
    assign o_overflow = i_ctl.push && (n_wr_ptr == n_rd_ptr);
    assign o_rdata    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            for (int i = 0; i < FIFO_DEPTH; i++) begin
                r_mem[i] <= '0;
            end
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            if (i_ctl.push) begin
                r_mem[r_wr_ptr] <= i_ctl.wdata;
            end
        end
    end

    a_rd_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_ptr <= PTR_LAST && r_wr_ptr <= PTR_LAST)
        else $error("fifo pointer beyond depth");

    a_no_push_wr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.push |=> $stable(r_wr_ptr))
        else $error("write pointer moved without a push");

endmodule

`default_nettype wire

>>> rtl/bslu_alu.sv
// ----------------------------------------------------------------------------
// bslu_alu
// Funnel shifter, raster operation, edge masks and read selection for one
// bus access.
// ----------------------------------------------------------------------------
`default_nettype none

module bslu_alu (
    input  wire                         i_fire,
    input  bslu_pkg::t_in_item          i_item,
    input  bslu_pkg::t_cfg              i_cfg,
    input  wire [bslu_pkg::WORD_W-1:0]  i_source_latch,
    input  wire [bslu_pkg::WORD_W-1:0]  i_logic_latch,
    input  wire [bslu_pkg::WORD_W-1:0]  i_popped_latch,
    input  wire [bslu_pkg::WORD_W-1:0]  i_fifo_rdata,
    output bslu_pkg::t_fifo_ctl         o_fifo_ctl,
    output bslu_pkg::t_latch_ctl        o_latch_ctl,
    output logic [bslu_pkg::WORD_W-1:0] o_logic_word,
    output logic [bslu_pkg::WORD_W-1:0] o_read_word
);
    import bslu_pkg::*;

    logic [2*WORD_W-1:0] w_both;
    logic [2*WORD_W-1:0] w_both_sh;
    logic [WORD_W-1:0]   w_shifted;
    logic [WORD_W-1:0]   w_src;
    logic [WORD_W-1:0]   w_rop;
    logic [WORD_W-1:0]   w_lmask;
    logic [WORD_W-1:0]   w_rmask;
    logic [WORD_W-1:0]   w_left;
    logic [WORD_W-1:0]   w_right;

    // funnel shift: high half of the 32-bit pair after a left shift
    always_comb begin
        w_both    = i_item.shift_direction ? {i_item.bus_word, i_source_latch}
                                           : {i_source_latch, i_item.bus_word};
        w_both_sh = w_both << i_cfg.barrel_shift;
        w_shifted = w_both_sh[2*WORD_W-1:WORD_W];
    end

    // each bit picks its minterm from the function code
    always_comb begin
        w_src = i_item.line_mode ? {WORD_W{i_item.pixel_level}} : i_fifo_rdata;
        for (int i = 0; i < WORD_W; i++) begin
            w_rop[i] = i_cfg.function_select[{w_src[i], i_item.bus_word[i]}];
        end
    end

    // masks keep destination bits outside the window
    always_comb begin
        w_lmask = WORD_ONES >> i_cfg.left_mask_shift;
        w_rmask = WORD_ONES << (SHIFT_MAX - i_cfg.right_mask_shift);
        w_left  = i_item.left_enable
                ? ((w_rop & w_lmask) | (i_item.bus_word & ~w_lmask)) : w_rop;
        w_right = i_item.right_enable
                ? ((w_left & w_rmask) | (i_item.bus_word & ~w_rmask)) : w_left;
    end

    assign o_logic_word = w_right;

    always_comb begin
        o_fifo_ctl  = '0;
        o_latch_ctl = '0;
        o_read_word = '0;
        case (i_item.operation)
            OP_SRC_WRITE: begin
                o_latch_ctl.source_we = i_fire;
                o_fifo_ctl.push       = i_fire && i_item.push_fifo;
                o_fifo_ctl.wdata      = w_shifted;
            end
            OP_DST_WRITE: begin
                o_fifo_ctl.pop        = i_fire && !i_item.line_mode;
                o_latch_ctl.popped_we = i_fire && !i_item.line_mode;
                o_latch_ctl.logic_we  = i_fire;
                o_fifo_ctl.push       = i_fire && i_item.push_fifo;
                o_fifo_ctl.wdata      = w_right;
            end
            OP_OUT_READ: begin
                o_read_word = i_item.output_select ? i_popped_latch : i_logic_latch;
            end
            OP_PIX_READ: begin
                // pixel 0 is the most significant bit
                o_read_word = {{(WORD_W-1){1'b0}}, i_logic_latch[~i_item.pixel_index]};
            end
            default: begin
                o_read_word = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/bitblt_shift_logic_unit.sv
// ----------------------------------------------------------------------------
// bitblt_shift_logic_unit
// 16-bit bitblt shift and raster-operation unit, one bus access per item.
//
// Channels: i_in takes one bus access (source write, destination write,
// output read or pixel read); o_out returns exactly one result word per
// access, zero for writes, with the overflow flag set when that access's
// push caught up with the fifo read pointer. Registers are written through
// i_cfg_we / i_cfg_index / i_cfg_wdata; the user must write them only while
// no access is in flight, the block itself does not enforce it.
// The result passes through the input register, then the result register.
// Throughput: one access per cycle while the receiver takes results, set by the
// single shift/raster/mask stage between the two registers; the source,
// logic and popped latches and the fifo pointers update as the access
// moves into the result register, so the next access sees them at once.
// Reset clears the configuration registers, valid bits, latches, fifo contents
// and pointers. When the receiver stalls, the result register holds and the
// input register keeps one more access; ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module bitblt_shift_logic_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  bslu_pkg::t_cfg_idx          i_cfg_index,
    input  wire [bslu_pkg::CFG_W-1:0]   i_cfg_wdata,
    bslu_in_if.sink                     i_in,
    bslu_out_if.source                  o_out
);
    import bslu_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [WORD_W-1:0] r_source_latch;
    logic [WORD_W-1:0] r_logic_latch;
    logic [WORD_W-1:0] r_popped_latch;

    logic        w_adv;
    t_fifo_ctl   w_fifo_ctl;
    t_latch_ctl  w_latch_ctl;
    logic [WORD_W-1:0] w_fifo_rdata;
    logic              w_overflow;
    logic [WORD_W-1:0] w_logic_word;
    logic [WORD_W-1:0] w_read_word;
    t_out_item   n_out_item;

    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FUNCTION_SELECT:  r_cfg.function_select  <= i_cfg_wdata;
                CFG_BARREL_SHIFT:     r_cfg.barrel_shift     <= i_cfg_wdata;
                CFG_LEFT_MASK_SHIFT:  r_cfg.left_mask_shift  <= i_cfg_wdata;
                CFG_RIGHT_MASK_SHIFT: r_cfg.right_mask_shift <= i_cfg_wdata;
                default:              r_cfg                  <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.item;
        end
    end

    bslu_alu u_alu (
        .i_fire         (w_adv),
        .i_item         (r_in_item),
        .i_cfg          (r_cfg),
        .i_source_latch (r_source_latch),
        .i_logic_latch  (r_logic_latch),
        .i_popped_latch (r_popped_latch),
        .i_fifo_rdata   (w_fifo_rdata),
        .o_fifo_ctl     (w_fifo_ctl),
        .o_latch_ctl    (w_latch_ctl),
        .o_logic_word   (w_logic_word),
        .o_read_word    (w_read_word)
    );

    bslu_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_fifo_ctl),
        .o_rdata    (w_fifo_rdata),
        .o_overflow (w_overflow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_latch <= '0;
            r_logic_latch  <= '0;
            r_popped_latch <= '0;
        end else begin
            if (w_latch_ctl.source_we) begin
                r_source_latch <= r_in_item.bus_word;
            end
            if (w_latch_ctl.logic_we) begin
                r_logic_latch <= w_logic_word;
            end
            if (w_latch_ctl.popped_we) begin
                r_popped_latch <= w_fifo_rdata;
            end
        end
    end

    // result register
    always_comb begin
        n_out_item.read_word     = w_read_word;
        n_out_item.fifo_overflow = w_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= n_out_item;
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("pending access dropped from input register");

    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced access produced no result");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_in_item.operation == OP_SRC_WRITE
                  || r_in_item.operation == OP_DST_WRITE)
        |=> r_out_item.read_word == '0)
        else $error("write returned nonzero read data");

    a_ovf_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !r_in_item.push_fifo |=> !r_out_item.fifo_overflow)
        else $error("overflow flagged without a push");

endmodule

`default_nettype wire

>>> sim/bitblt_shift_logic_unit_test.sv
// ----------------------------------------------------------------------------
// bitblt_shift_logic_unit_test
// Self-checking bench for the bitblt shift and logic unit. Bus accesses go
// in through the input channel in random bursts while the result channel
// stalls on its own pattern. A scoreboard keeps a copy of the latches, fifo
// and registers, predicts one result word per accepted access and compares
// every returned word field by field, over several register settings.
// ----------------------------------------------------------------------------
module bitblt_shift_logic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bslu_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES      = 6;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_PRINTED     = 30;

    class bslu_scoreboard;
        t_cfg               cfg;
        logic [WORD_W-1:0]  source_q;
        logic [WORD_W-1:0]  logic_q;
        logic [WORD_W-1:0]  popped_q;
        logic [WORD_W-1:0]  fifo_mem [FIFO_DEPTH];
        logic [FIFO_AW-1:0] rd_ptr;
        logic [FIFO_AW-1:0] wr_ptr;
        t_out_item          expected_q [$];
        int                 errors;

        function new();
            cfg      = '0;
            source_q = '0;
            logic_q  = '0;
            popped_q = '0;
            rd_ptr   = '0;
            wr_ptr   = '0;
            errors   = 0;
            foreach (fifo_mem[i]) fifo_mem[i] = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_FUNCTION_SELECT:  cfg.function_select  = v;
                CFG_BARREL_SHIFT:     cfg.barrel_shift     = v;
                CFG_LEFT_MASK_SHIFT:  cfg.left_mask_shift  = v;
                CFG_RIGHT_MASK_SHIFT: cfg.right_mask_shift = v;
                default:              cfg                  = cfg;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // push wraps and overwrites, flag when the writer lands on the reader
        function logic push_word(logic [WORD_W-1:0] w);
            fifo_mem[wr_ptr] = w;
            wr_ptr = wr_ptr + 1'b1;
            return wr_ptr == rd_ptr;
        endfunction

        function void note_access(t_in_item w);
            t_out_item           res;
            logic [2*WORD_W-1:0] both;
            logic [WORD_W-1:0]   src;
            logic [WORD_W-1:0]   r;
            logic [WORD_W-1:0]   m;
            res = '0;
            case (w.operation)
                OP_SRC_WRITE: begin
                    if (w.push_fifo) begin
                        both = w.shift_direction ? {w.bus_word, source_q}
                                                 : {source_q, w.bus_word};
                        both = both << cfg.barrel_shift;
                        res.fifo_overflow = push_word(both[2*WORD_W-1:WORD_W]);
                    end
                    source_q = w.bus_word;
                end
                OP_DST_WRITE: begin
                    if (w.line_mode) begin
                        src = {WORD_W{w.pixel_level}};
                    end else begin
                        popped_q = fifo_mem[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        src = popped_q;
                    end
                    r = ({WORD_W{cfg.function_select[3]}} &  src &  w.bus_word)
                      | ({WORD_W{cfg.function_select[2]}} &  src & ~w.bus_word)
                      | ({WORD_W{cfg.function_select[1]}} & ~src &  w.bus_word)
                      | ({WORD_W{cfg.function_select[0]}} & ~src & ~w.bus_word);
                    // masks keep destination bits outside the window
                    if (w.left_enable) begin
                        m = WORD_ONES >> cfg.left_mask_shift;
                        r = (r & m) | (w.bus_word & ~m);
                    end
                    if (w.right_enable) begin
                        m = WORD_ONES << (SHIFT_MAX - cfg.right_mask_shift);
                        r = (r & m) | (w.bus_word & ~m);
                    end
                    logic_q = r;
                    if (w.push_fifo) res.fifo_overflow = push_word(r);
                end
                OP_OUT_READ: begin
                    res.read_word = w.output_select ? popped_q : logic_q;
                end
                OP_PIX_READ: begin
                    res.read_word = {{(WORD_W-1){1'b0}},
                                     logic_q[SHIFT_MAX - w.pixel_index]};
                end
                default: begin
                    res = '0;
                end
            endcase
            expected_q.push_back(res);
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report($sformatf("word %h/%b with no access pending",
                                 got.read_word, got.fifo_overflow));
                return;
            end
            want = expected_q.pop_front();
            if (got.read_word !== want.read_word)
                report($sformatf("read_word %h, predicted %h",
                                 got.read_word, want.read_word));
            if (got.fifo_overflow !== want.fifo_overflow)
                report($sformatf("fifo_overflow %b, predicted %b",
                                 got.fifo_overflow, want.fifo_overflow));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    t_cfg_idx           i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_wdata;

    bslu_in_if  in_if ();
    bslu_out_if out_if ();

    bitblt_shift_logic_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    bslu_scoreboard sb = new();

    int sent        = 0;
    int burst_left  = 0;
    int cycles      = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: checks each accepted word and stalls on a changing pattern
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.item);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        stall_count++;
        case (stall_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= ($urandom_range(0, 3) != 0);
            2:       out_if.ready <= ((stall_count % 7) < 4);
            default: out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return WORD_ONES;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_access(t_op op, logic [WORD_W-1:0] bus,
                                             logic push, logic dir, logic line,
                                             logic level, logic len, logic ren,
                                             logic osel, logic [SHIFT_W-1:0] pix);
        t_in_item w;
        w.operation       = op;
        w.bus_word        = bus;
        w.push_fifo       = push;
        w.shift_direction = dir;
        w.line_mode       = line;
        w.pixel_level     = level;
        w.left_enable     = len;
        w.right_enable    = ren;
        w.output_select   = osel;
        w.pixel_index     = pix;
        return w;
    endfunction

    function automatic t_in_item random_access();
        logic [31:0] bits;
        bits = $urandom;
        return make_access(t_op'($urandom_range(0, 3)), rand_word(), bits[0], bits[1],
                           bits[2], bits[3], bits[4], bits[5], bits[6], bits[11:8]);
    endfunction

    // sender works in bursts, gaps fall in front of a burst
    task automatic send_access(input t_in_item w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.item  <= w;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_access(w);
        sent++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_config(input t_cfg c);
        logic [CFG_W-1:0] v;
        t_cfg_idx         idx;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_FUNCTION_SELECT:  v = c.function_select;
                CFG_BARREL_SHIFT:     v = c.barrel_shift;
                CFG_LEFT_MASK_SHIFT:  v = c.left_mask_shift;
                CFG_RIGHT_MASK_SHIFT: v = c.right_mask_shift;
                default:              v = '0;
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_wdata <= v;
            @(posedge i_clk);
            sb.set_reg(idx, v);
        end
        i_cfg_we <= 1'b0;
    endtask

    // source row pushed into the fifo, then popped by destination writes
    task automatic run_blit_row();
        int       n;
        logic     dir;
        t_in_item w;
        n   = $urandom_range(1, 6);
        dir = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1))
            send_access(make_access(OP_SRC_WRITE, rand_word(), 1'b0, dir,
                                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
        for (int i = 0; i < n; i++)
            send_access(make_access(OP_SRC_WRITE, rand_word(), 1'b1, dir,
                                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
        for (int i = 0; i < n; i++) begin
            w = random_access();
            w.operation    = OP_DST_WRITE;
            w.line_mode    = 1'b0;
            w.left_enable  = (i == 0);
            w.right_enable = (i == n - 1);
            w.push_fifo    = ($urandom_range(0, 3) == 0);
            send_access(w);
        end
        w = random_access();
        w.operation = OP_OUT_READ;
        send_access(w);
        w.operation = OP_PIX_READ;
        send_access(w);
    endtask

    task automatic run_line();
        int       n;
        t_in_item w;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            w = random_access();
            w.operation = OP_DST_WRITE;
            w.line_mode = 1'b1;
            send_access(w);
        end
        w = random_access();
        w.operation = OP_PIX_READ;
        send_access(w);
    endtask

    // unbalanced traffic: pops past empty, or pushes past full
    task automatic run_unbalanced();
        int       n;
        t_in_item w;
        if ($urandom_range(0, 1)) begin
            n = $urandom_range(2, 5);
            for (int i = 0; i < n; i++) begin
                w = random_access();
                w.operation = OP_DST_WRITE;
                w.line_mode = 1'b0;
                w.push_fifo = 1'b0;
                send_access(w);
            end
        end else begin
            n = $urandom_range(10, 20);
            for (int i = 0; i < n; i++) begin
                w = random_access();
                w.operation = OP_SRC_WRITE;
                w.push_fifo = 1'b1;
                send_access(w);
            end
        end
    endtask

    initial begin
        t_cfg        c;
        logic [31:0] rnd;
        int          target;
        int          pick;
        int          n;
        logic        paused;

        paused       = 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_FUNCTION_SELECT;
        i_cfg_wdata  <= '0;
        in_if.valid  <= 1'b0;
        in_if.item   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // copy source, zero shift, masks that keep everything
        write_config({4'b1100, 4'd0, 4'd0, 4'd15});
        send_access(make_access(OP_SRC_WRITE, 16'ha5c3, 1'b1, 1'b1, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_SRC_WRITE, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_DST_WRITE, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b1, 1'b1, 1'b0, 4'd0));
        send_access(make_access(OP_OUT_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b1, 4'd0));
        wait_drained();

        // xor with the widest shift and narrow masks
        write_config({4'b0110, 4'd15, 4'd4, 4'd10});
        send_access(make_access(OP_SRC_WRITE, 16'hffff, 1'b0, 1'b1, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_SRC_WRITE, 16'h8001, 1'b1, 1'b1, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_SRC_WRITE, 16'h7ffe, 1'b1, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_DST_WRITE, 16'h0f0f, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_DST_WRITE, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0,
                                1'b1, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_DST_WRITE, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b1, 1'b0, 4'd0));
        send_access(make_access(OP_DST_WRITE, 16'hc3c3, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        // fifo is empty here, the pop still moves the read pointer
        send_access(make_access(OP_DST_WRITE, 16'h1234, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b1, 1'b1, 1'b0, 4'd0));
        // reader is one ahead, this push catches it
        send_access(make_access(OP_SRC_WRITE, 16'h5555, 1'b1, 1'b1, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_DST_WRITE, 16'h00ff, 1'b0, 1'b0, 1'b1, 1'b1,
                                1'b1, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_DST_WRITE, 16'hff00, 1'b1, 1'b0, 1'b1, 1'b0,
                                1'b0, 1'b1, 1'b0, 4'd0));
        send_access(make_access(OP_OUT_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_OUT_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b1, 4'd0));
        send_access(make_access(OP_PIX_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd0));
        send_access(make_access(OP_PIX_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd15));
        send_access(make_access(OP_PIX_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0,
                                1'b0, 1'b0, 1'b0, 4'd6));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       c = '0;
                1:       c = '1;
                default: begin
                    rnd = $urandom;
                    c   = rnd[15:0];
                end
            endcase
            wait_drained();
            write_config(c);
            target = sent + ITEMS_PER_PHASE;
            while (sent < target) begin
                if (phase == 2 && !paused && sent >= target - ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    run_blit_row();
                end else if (pick < 65) begin
                    run_line();
                end else if (pick < 85) begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_access(random_access());
                end else begin
                    run_unbalanced();
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("accesses left without a result");
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
